FILE: rtl/core/playfair_cipher_stream_defines.svh
// Assertion macros for the cipher stream checkers.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef PLAYFAIR_CIPHER_STREAM_DEFINES_SVH
`define PLAYFAIR_CIPHER_STREAM_DEFINES_SVH

// Same-cycle implication.
`define PFS_ASSERT_IMP(label, ante, cons, text) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(text);

// Next-cycle implication.
`define PFS_ASSERT_NEXT(label, ante, cons, text) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(text);

`endif

FILE: rtl/core/pfs_pkg.sv
package pfs_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CODE_W      = 5;
	localparam int ROW_W       = SQUARE_SIDE * CODE_W;
	localparam int IDX_W       = $clog2(SQUARE_SIDE);
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = ROW_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int PUSH_MAX    = 2;
	localparam int PUSH_W      = $clog2(PUSH_MAX + 1);

	localparam logic [CODE_W-1:0] CODE_X    = CODE_W'(23);
	localparam logic [CODE_W-1:0] CODE_NONE = CODE_W'(31);
	localparam logic [CODE_W-1:0] CODE_MAX  = CODE_W'(25);

	localparam logic [BYTE_W-1:0] CHAR_A    = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_Z    = 8'h7a;
	localparam logic [BYTE_W-1:0] CHAR_J    = 8'h6a;
	localparam logic [BYTE_W-1:0] CHAR_NL   = 8'h0a;
	localparam logic [BYTE_W-1:0] CASE_BIT  = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CIPHER_MODE = 3'd0,
		REG_SQUARE_ROW0 = 3'd1,
		REG_SQUARE_ROW1 = 3'd2,
		REG_SQUARE_ROW2 = 3'd3,
		REG_SQUARE_ROW3 = 3'd4,
		REG_SQUARE_ROW4 = 3'd5
	} cfg_reg_t;

	typedef logic [SQUARE_SIDE-1:0][ROW_W-1:0] square_t;

	// a..z without j, row-major
	localparam square_t SQUARE_RESET = {
		ROW_W'(27025109), ROW_W'(21613104), ROW_W'(16201099),
		ROW_W'(10755269), ROW_W'(4294688)
	};

	typedef struct packed {
		logic    mode;
		square_t square;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] letter;
		logic              letter_valid;
		logic              pair_second;
		logic              message_end;
		logic              bad_input;
	} result_t;

	typedef struct packed {
		logic [PUSH_W-1:0] n;
		result_t           first;
		result_t           second;
	} push_t;

	typedef struct packed {
		logic              mode;
		logic [CODE_W-1:0] code_a;
		logic [CODE_W-1:0] code_b;
	} pair_req_t;

	typedef struct packed {
		logic              found;
		logic [CODE_W-1:0] x;
		logic [CODE_W-1:0] y;
	} pair_res_t;

	function automatic logic [BYTE_W-1:0] letter_of(input logic [CODE_W-1:0] code);
		return CHAR_A + BYTE_W'(code);
	endfunction

endpackage

FILE: rtl/core/pfs_stream_if.sv
interface pfs_msg_if;
	logic                      valid;
	logic                      ready;
	logic [pfs_pkg::BYTE_W-1:0] in_byte;
	logic                      in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface pfs_res_if;
	logic                      valid;
	logic                      ready;
	logic [pfs_pkg::BYTE_W-1:0] out_letter;
	logic                      letter_valid;
	logic                      pair_second;
	logic                      message_end;
	logic                      bad_input;

	modport source (
		output valid, output out_letter, output letter_valid, output pair_second,
		output message_end, output bad_input, input ready
	);
	modport sink (
		input valid, input out_letter, input letter_valid, input pair_second,
		input message_end, input bad_input, output ready
	);
endinterface

FILE: rtl/core/playfair_cipher_stream.sv
// Channel | Dir | Fields                                                  | Word
// msg     | in  | in_byte, in_last                                        | one message byte
// res     | out | out_letter, letter_valid, pair_second, message_end,     | one result
//         |     | bad_input                                               |
// One byte is taken per cycle while the queue has room; the byte that completes a pair
// is registered, then both result words are written to the queue, the second behind the first.
// The square lookup and pair swap sit between the byte register and a four-word
// result queue; the byte register holds its word while more than two words wait in it.
// arst_n clears the queue, the held letter and the previous byte (newline) and loads
// the default square; a stalled res side only holds the queue, nothing is dropped.
module playfair_cipher_stream (
	input  logic                           clk,
	input  logic                           arst_n,
	pfs_msg_if.sink                        msg,
	pfs_res_if.source                      res,
	input  logic                           wr_en,
	input  logic [pfs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pfs_pkg::CFG_DATA_W-1:0] wr_data
);

	pfs_pkg::cfg_t  cfg;
	pfs_pkg::push_t push;
	logic           room;

	pfs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	pfs_prep_stage u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	pfs_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.res    (res)
	);

endmodule

FILE: rtl/core/pfs_cfg_regs.sv
module pfs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pfs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pfs_pkg::CFG_DATA_W-1:0] wr_data,
	output pfs_pkg::cfg_t                  cfg
);

	logic             mode_q;
	pfs_pkg::square_t square_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			square_q <= pfs_pkg::SQUARE_RESET;
		end else if (wr_en) begin
			unique case (pfs_pkg::cfg_reg_t'(wr_index))
				pfs_pkg::REG_CIPHER_MODE: mode_q      <= wr_data[0];
				pfs_pkg::REG_SQUARE_ROW0: square_q[0] <= wr_data[pfs_pkg::ROW_W-1:0];
				pfs_pkg::REG_SQUARE_ROW1: square_q[1] <= wr_data[pfs_pkg::ROW_W-1:0];
				pfs_pkg::REG_SQUARE_ROW2: square_q[2] <= wr_data[pfs_pkg::ROW_W-1:0];
				pfs_pkg::REG_SQUARE_ROW3: square_q[3] <= wr_data[pfs_pkg::ROW_W-1:0];
				pfs_pkg::REG_SQUARE_ROW4: square_q[4] <= wr_data[pfs_pkg::ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.mode   = mode_q;
	assign cfg.square = square_q;

endmodule

FILE: rtl/core/pfs_pair_xform.sv
module pfs_pair_xform (
	input  pfs_pkg::square_t   square,
	input  pfs_pkg::pair_req_t req,
	output pfs_pkg::pair_res_t res
);

	localparam logic [pfs_pkg::IDX_W-1:0] LAST_IDX = pfs_pkg::IDX_W'(pfs_pkg::SQUARE_SIDE - 1);

	logic                        found_a, found_b;
	logic [pfs_pkg::IDX_W-1:0]   ra, ca, rb, cb;

	function automatic logic [pfs_pkg::CODE_W-1:0] cell_at(
		input pfs_pkg::square_t          sq,
		input logic [pfs_pkg::IDX_W-1:0] r,
		input logic [pfs_pkg::IDX_W-1:0] c
	);
		return sq[r][c * pfs_pkg::CODE_W +: pfs_pkg::CODE_W];
	endfunction

	function automatic logic [pfs_pkg::IDX_W-1:0] step(
		input logic [pfs_pkg::IDX_W-1:0] i,
		input logic                      back
	);
		logic [pfs_pkg::IDX_W-1:0] n;
		if (back)
			n = (i == '0) ? LAST_IDX : i - 1'b1;
		else
			n = (i == LAST_IDX) ? '0 : i + 1'b1;
		return n;
	endfunction

	// first match in row-major order wins
	always_comb begin
		found_a = 1'b0;
		found_b = 1'b0;
		ra = '0;
		ca = '0;
		rb = '0;
		cb = '0;
		for (int r = pfs_pkg::SQUARE_SIDE - 1; r >= 0; r--) begin
			for (int c = pfs_pkg::SQUARE_SIDE - 1; c >= 0; c--) begin
				if (square[r][c * pfs_pkg::CODE_W +: pfs_pkg::CODE_W] == req.code_a) begin
					found_a = 1'b1;
					ra = pfs_pkg::IDX_W'(r);
					ca = pfs_pkg::IDX_W'(c);
				end
				if (square[r][c * pfs_pkg::CODE_W +: pfs_pkg::CODE_W] == req.code_b) begin
					found_b = 1'b1;
					rb = pfs_pkg::IDX_W'(r);
					cb = pfs_pkg::IDX_W'(c);
				end
			end
		end
		found_a = found_a && (req.code_a <= pfs_pkg::CODE_MAX);
		found_b = found_b && (req.code_b <= pfs_pkg::CODE_MAX);
	end

	always_comb begin
		res.found = found_a && found_b;
		priority if (ca == cb) begin
			res.x = cell_at(square, step(ra, req.mode), ca);
			res.y = cell_at(square, step(rb, req.mode), cb);
		end else if (ra == rb) begin
			res.x = cell_at(square, ra, step(ca, req.mode));
			res.y = cell_at(square, rb, step(cb, req.mode));
		end else begin
			res.x = cell_at(square, ra, cb);
			res.y = cell_at(square, rb, ca);
		end
	end

endmodule

FILE: rtl/core/pfs_prep_stage.sv
module pfs_prep_stage (
	input  logic          clk,
	input  logic          arst_n,
	pfs_msg_if.sink       msg,
	input  pfs_pkg::cfg_t cfg,
	input  logic          room,
	output pfs_pkg::push_t push
);

	logic [pfs_pkg::BYTE_W-1:0] byte_s1;
	logic                       last_s1;
	logic                       valid_s1;

	logic [pfs_pkg::CODE_W-1:0] held_q;
	logic                       held_valid_q;
	logic [pfs_pkg::BYTE_W-1:0] prev_q;

	logic                       fire;
	logic                       have;
	logic [pfs_pkg::CODE_W-1:0] code;
	logic [pfs_pkg::BYTE_W-1:0] lc, lp;
	logic                       is_letter, prev_letter;
	logic [pfs_pkg::PUSH_W-1:0] n;
	pfs_pkg::result_t           r0, r1;
	pfs_pkg::result_t           pr0, pr1;
	pfs_pkg::pair_req_t         req;
	pfs_pkg::pair_res_t         pres;

	assign fire      = valid_s1 && room;
	assign msg.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.valid && msg.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			byte_s1 <= msg.in_byte;
			last_s1 <= msg.in_last;
		end
	end

	// letter preparation
	always_comb begin
		lc          = byte_s1 | pfs_pkg::CASE_BIT;
		lp          = prev_q | pfs_pkg::CASE_BIT;
		is_letter   = (lc >= pfs_pkg::CHAR_A) && (lc <= pfs_pkg::CHAR_Z);
		prev_letter = (lp >= pfs_pkg::CHAR_A) && (lp <= pfs_pkg::CHAR_Z);
		code        = '0;
		have        = 1'b0;
		if (cfg.mode) begin
			have = 1'b1;
			if ((byte_s1 >= pfs_pkg::CHAR_A) && (byte_s1 <= pfs_pkg::CHAR_Z))
				code = pfs_pkg::CODE_W'(byte_s1 - pfs_pkg::CHAR_A);
			else
				code = pfs_pkg::CODE_NONE;
		end else if (is_letter) begin
			if (prev_letter && (lc == lp)) begin
				code = pfs_pkg::CODE_X;
				have = 1'b1;
			end else if (lc != pfs_pkg::CHAR_J) begin
				code = pfs_pkg::CODE_W'(lc - pfs_pkg::CHAR_A);
				have = 1'b1;
			end
		end
	end

	always_comb begin
		req.mode   = cfg.mode;
		req.code_a = held_valid_q ? held_q : code;
		req.code_b = (have && held_valid_q) ? code : pfs_pkg::CODE_X;
	end

	pfs_pair_xform u_xform (
		.square (cfg.square),
		.req    (req),
		.res    (pres)
	);

	always_comb begin
		if (pres.found) begin
			pr0 = '{letter: pfs_pkg::letter_of(pres.x), letter_valid: 1'b1,
				pair_second: 1'b0, message_end: 1'b0, bad_input: 1'b0};
			pr1 = '{letter: pfs_pkg::letter_of(pres.y), letter_valid: 1'b1,
				pair_second: 1'b1, message_end: 1'b0, bad_input: 1'b0};
		end else if (cfg.mode) begin
			pr0 = '{letter: '0, letter_valid: 1'b0,
				pair_second: 1'b0, message_end: 1'b0, bad_input: 1'b1};
			pr1 = '{letter: '0, letter_valid: 1'b0,
				pair_second: 1'b1, message_end: 1'b0, bad_input: 1'b1};
		end else begin
			pr0 = '{letter: pfs_pkg::letter_of(req.code_a), letter_valid: 1'b1,
				pair_second: 1'b0, message_end: 1'b0, bad_input: 1'b0};
			pr1 = '{letter: pfs_pkg::letter_of(req.code_b), letter_valid: 1'b1,
				pair_second: 1'b1, message_end: 1'b0, bad_input: 1'b0};
		end
	end

	always_comb begin
		r0 = pr0;
		r1 = pr1;
		priority if (have && held_valid_q) begin
			n = pfs_pkg::PUSH_W'(2);
		end else if (last_s1 && (have || held_valid_q)) begin
			if (cfg.mode) begin
				// odd tail
				r0 = '{letter: '0, letter_valid: 1'b0,
					pair_second: 1'b0, message_end: 1'b0, bad_input: 1'b1};
				n  = pfs_pkg::PUSH_W'(1);
			end else begin
				n  = pfs_pkg::PUSH_W'(2);
			end
		end else if (last_s1) begin
			r0 = '0;
			n  = pfs_pkg::PUSH_W'(1);
		end else begin
			n = '0;
		end
		if (last_s1) begin
			if (n == pfs_pkg::PUSH_W'(2))
				r1.message_end = 1'b1;
			else
				r0.message_end = 1'b1;
		end
	end

	assign push.n      = fire ? n : '0;
	assign push.first  = r0;
	assign push.second = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
			prev_q       <= pfs_pkg::CHAR_NL;
		end else if (fire) begin
			if (last_s1) begin
				held_valid_q <= 1'b0;
				prev_q       <= pfs_pkg::CHAR_NL;
			end else begin
				prev_q <= byte_s1;
				if (have) begin
					held_valid_q <= !held_valid_q;
					if (!held_valid_q)
						held_q <= code;
				end
			end
			if (last_s1 && have && !held_valid_q)
				held_q <= code;
		end
	end

endmodule

FILE: rtl/core/pfs_result_queue.sv
module pfs_result_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  pfs_pkg::push_t push,
	output logic           room,
	pfs_res_if.source      res
);

	pfs_pkg::result_t           entry_q [pfs_pkg::QUEUE_DEPTH];
	logic [pfs_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [pfs_pkg::QCNT_W-1:0] count_q;
	logic                       pop;
	pfs_pkg::result_t           head;

	assign pop  = res.valid && res.ready;
	assign room = count_q <= pfs_pkg::QCNT_W'(pfs_pkg::QUEUE_DEPTH - pfs_pkg::PUSH_MAX);
	assign head = entry_q[rd_q];

	assign res.valid        = count_q != '0;
	assign res.out_letter   = head.letter;
	assign res.letter_valid = head.letter_valid;
	assign res.pair_second  = head.pair_second;
	assign res.message_end  = head.message_end;
	assign res.bad_input    = head.bad_input;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + pfs_pkg::QPTR_W'(push.n);
			rd_q    <= rd_q + pfs_pkg::QPTR_W'(pop);
			count_q <= count_q + pfs_pkg::QCNT_W'(push.n) - pfs_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != '0)
			entry_q[wr_q] <= push.first;
		if (push.n == pfs_pkg::PUSH_W'(2))
			entry_q[wr_q + 1'b1] <= push.second;
	end

endmodule

FILE: rtl/core/pfs_checker.sv
`include "playfair_cipher_stream_defines.svh"

module pfs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [pfs_pkg::BYTE_W-1:0]  out_letter,
	input logic                        letter_valid,
	input logic                        pair_second,
	input logic                        message_end,
	input logic                        bad_input
);

	`PFS_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(out_letter) && $stable(message_end), "result word changed while stalled")
	`PFS_ASSERT_IMP(a_bad_blank, out_valid && bad_input, !letter_valid && (out_letter == 8'd0), "flagged word carries a letter")
	`PFS_ASSERT_IMP(a_empty_end, out_valid && !letter_valid && !bad_input, message_end && !pair_second && (out_letter == 8'd0), "blank word is not a bare end marker")
	`PFS_ASSERT_IMP(a_idle_ready, !out_valid, in_ready, "input held off with no result waiting")

endmodule

bind playfair_cipher_stream pfs_checker u_pfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (msg.ready),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.out_letter   (res.out_letter),
	.letter_valid (res.letter_valid),
	.pair_second  (res.pair_second),
	.message_end  (res.message_end),
	.bad_input    (res.bad_input)
);

FILE: tb/sv/playfair_cipher_stream_tb.sv
module playfair_cipher_stream_tb;

	localparam int HALF_PERIOD    = 6;
	localparam int STALL_LIMIT    = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 90;
	localparam int SETTLE_CYCLES  = 10;
	localparam int SQUEEZE_AT     = 300;
	localparam int SQUEEZE_CYCLES = 120;
	localparam int DIR_ROWS       = 28;

	typedef enum logic {ROW_WORD, ROW_MODE} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [7:0]       data;
		logic             fin;
		logic [1:0]       ntyped;
		pfs_pkg::result_t r0;
		pfs_pkg::result_t r1;
	} dir_row_t;

	localparam pfs_pkg::result_t NO_RES = '0;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           wr_en    = 1'b0;
	logic [pfs_pkg::CFG_IDX_W-1:0]  wr_index = '0;
	logic [pfs_pkg::CFG_DATA_W-1:0] wr_data  = '0;

	pfs_msg_if msg_ch();
	pfs_res_if res_ch();

	playfair_cipher_stream uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// predictor state
	logic                       key_mode;
	logic [pfs_pkg::ROW_W-1:0]  key_rows [pfs_pkg::SQUARE_SIDE];
	logic [pfs_pkg::CODE_W-1:0] held_code;
	logic                       held_ok;
	logic [7:0]                 prior_byte;
	pfs_pkg::result_t           step_letters [2];
	int                         step_count;

	pfs_pkg::result_t pending_letters [$];
	dir_row_t         dir_rows [DIR_ROWS];
	int               mismatches = 0;
	int               words_sent = 0;
	bit               calm = 1'b0;

	function automatic pfs_pkg::result_t res_word(input logic [7:0] l, input logic v,
			input logic s, input logic e, input logic b);
		pfs_pkg::result_t w;
		w.letter       = l;
		w.letter_valid = v;
		w.pair_second  = s;
		w.message_end  = e;
		w.bad_input    = b;
		return w;
	endfunction

	function automatic logic [pfs_pkg::CODE_W-1:0] cell_at(input int r, input int c);
		return key_rows[r % pfs_pkg::SQUARE_SIDE][pfs_pkg::CODE_W * (c % pfs_pkg::SQUARE_SIDE)
			+: pfs_pkg::CODE_W];
	endfunction

	function automatic logic find_cell(input logic [pfs_pkg::CODE_W-1:0] code, output int r,
			output int c);
		r = 0;
		c = 0;
		if (code > pfs_pkg::CODE_MAX)
			return 1'b0;
		for (int i = 0; i < pfs_pkg::SQUARE_SIDE; i++)
			for (int k = 0; k < pfs_pkg::SQUARE_SIDE; k++)
				if (cell_at(i, k) == code) begin
					r = i;
					c = k;
					return 1'b1;
				end
		return 1'b0;
	endfunction

	function automatic void cipher_pair(input logic [pfs_pkg::CODE_W-1:0] a,
			input logic [pfs_pkg::CODE_W-1:0] b);
		int r1, c1, r2, c2, d;
		logic ok1, ok2;
		logic [pfs_pkg::CODE_W-1:0] x, y;
		ok1 = find_cell(a, r1, c1);
		ok2 = find_cell(b, r2, c2);
		d = key_mode ? pfs_pkg::SQUARE_SIDE - 1 : 1;
		step_count = 2;
		if (!(ok1 && ok2)) begin
			if (key_mode) begin
				step_letters[0] = res_word(8'h00, 0, 0, 0, 1);
				step_letters[1] = res_word(8'h00, 0, 1, 0, 1);
			end else begin
				step_letters[0] = res_word(pfs_pkg::CHAR_A + 8'(a), 1, 0, 0, 0);
				step_letters[1] = res_word(pfs_pkg::CHAR_A + 8'(b), 1, 1, 0, 0);
			end
			return;
		end
		if (c1 == c2) begin
			x = cell_at(r1 + d, c1);
			y = cell_at(r2 + d, c2);
		end else if (r1 == r2) begin
			x = cell_at(r1, c1 + d);
			y = cell_at(r2, c2 + d);
		end else begin
			x = cell_at(r1, c2);
			y = cell_at(r2, c1);
		end
		step_letters[0] = res_word(pfs_pkg::CHAR_A + 8'(x), 1, 0, 0, 0);
		step_letters[1] = res_word(pfs_pkg::CHAR_A + 8'(y), 1, 1, 0, 0);
	endfunction

	function automatic void cipher_step(input logic [7:0] b, input logic fin);
		logic [7:0] lc, lp;
		logic [pfs_pkg::CODE_W-1:0] code;
		logic have;
		step_count = 0;
		have = 1'b0;
		code = '0;
		if (!key_mode) begin
			lc = b | pfs_pkg::CASE_BIT;
			lp = prior_byte | pfs_pkg::CASE_BIT;
			if (lc >= pfs_pkg::CHAR_A && lc <= pfs_pkg::CHAR_Z) begin
				if (lp >= pfs_pkg::CHAR_A && lp <= pfs_pkg::CHAR_Z && lc == lp) begin
					code = pfs_pkg::CODE_X;
					have = 1'b1;
				end else if (lc != pfs_pkg::CHAR_J) begin
					code = pfs_pkg::CODE_W'(lc - pfs_pkg::CHAR_A);
					have = 1'b1;
				end
			end
		end else begin
			code = (b >= pfs_pkg::CHAR_A && b <= pfs_pkg::CHAR_Z) ?
				pfs_pkg::CODE_W'(b - pfs_pkg::CHAR_A) : pfs_pkg::CODE_NONE;
			have = 1'b1;
		end
		prior_byte = b;
		if (have) begin
			if (held_ok) begin
				cipher_pair(held_code, code);
				held_ok = 1'b0;
			end else begin
				held_code = code;
				held_ok = 1'b1;
			end
		end
		if (fin) begin
			if (held_ok) begin
				if (!key_mode)
					cipher_pair(held_code, pfs_pkg::CODE_X);
				else begin
					step_letters[0] = res_word(8'h00, 0, 0, 0, 1);
					step_count = 1;
				end
				held_ok = 1'b0;
			end
			if (step_count == 0) begin
				step_letters[0] = NO_RES;
				step_count = 1;
			end
			step_letters[step_count - 1].message_end = 1'b1;
			prior_byte = pfs_pkg::CHAR_NL;
		end
	endfunction

	task automatic report_fault(input string what, input pfs_pkg::result_t want,
			input pfs_pkg::result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %h v%b s%b e%b bad%b, got %h v%b s%b e%b bad%b", what,
				want.letter, want.letter_valid, want.pair_second, want.message_end,
				want.bad_input, got.letter, got.letter_valid, got.pair_second,
				got.message_end, got.bad_input);
	endtask

	task automatic offer_word(input logic [7:0] b, input logic fin);
		if (!calm && $urandom_range(0, 5) == 0) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		msg_ch.valid   <= 1'b1;
		msg_ch.in_byte <= b;
		msg_ch.in_last <= fin;
		do @(posedge clk); while (!msg_ch.ready);
		words_sent++;
		cipher_step(b, fin);
	endtask

	task automatic enqueue_word(input pfs_pkg::result_t w);
		pending_letters.insert(pending_letters.size(), w);
	endtask

	task automatic take_prediction();
		for (int k = 0; k < step_count; k++)
			enqueue_word(step_letters[k]);
	endtask

	task automatic write_reg(input pfs_pkg::cfg_reg_t idx,
			input logic [pfs_pkg::CFG_DATA_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		if (idx == pfs_pkg::REG_CIPHER_MODE)
			key_mode = val[0];
		else
			key_rows[int'(idx) - int'(pfs_pkg::REG_SQUARE_ROW0)] = val;
	endtask

	// drop valid, drain the result queue, let the pipeline go quiet
	task automatic settle();
		msg_ch.valid <= 1'b0;
		while (pending_letters.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [pfs_pkg::ROW_W-1:0]  plan_rows [pfs_pkg::SQUARE_SIDE];
		logic [pfs_pkg::CODE_W-1:0] codes [26];
		logic [pfs_pkg::CODE_W-1:0] t;
		logic                       plan_mode;
		logic [7:0]                 b, prev;
		int                         quota, len, roll, k, r, c;
		msg_ch.valid   = 1'b0;
		msg_ch.in_byte = '0;
		msg_ch.in_last = 1'b0;
		key_mode   = 1'b0;
		foreach (key_rows[i])
			key_rows[i] = pfs_pkg::SQUARE_RESET[i];
		held_code  = '0;
		held_ok    = 1'b0;
		prior_byte = pfs_pkg::CHAR_NL;
		dir_rows = '{
			'{ROW_WORD, "a", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "b", 1'b0, 2'd2, res_word("b", 1, 0, 0, 0), res_word("c", 1, 1, 0, 0)},
			'{ROW_WORD, 8'h00, 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, 8'hff, 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "J", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "Z", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "z", 1'b0, 2'd2, res_word("v", 1, 0, 0, 0), res_word("y", 1, 1, 0, 0)},
			'{ROW_WORD, 8'h40, 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, 8'h7b, 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "a", 1'b1, 2'd2, res_word("c", 1, 0, 0, 0), res_word("v", 1, 1, 1, 0)},
			'{ROW_WORD, 8'h60, 1'b1, 2'd1, res_word(8'h00, 0, 0, 1, 0), NO_RES},
			'{ROW_WORD, "a", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "v", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "j", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "J", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "k", 1'b1, 2'd0, NO_RES, NO_RES},
			'{ROW_MODE, 8'd1, 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "b", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "c", 1'b0, 2'd2, res_word("a", 1, 0, 0, 0), res_word("b", 1, 1, 0, 0)},
			'{ROW_WORD, "a", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "A", 1'b0, 2'd2, res_word(8'h00, 0, 0, 0, 1), res_word(8'h00, 0, 1, 0, 1)},
			'{ROW_WORD, "z", 1'b1, 2'd1, res_word(8'h00, 0, 0, 1, 1), NO_RES},
			'{ROW_WORD, "q", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "w", 1'b1, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "e", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_MODE, 8'd0, 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, "e", 1'b0, 2'd0, NO_RES, NO_RES},
			'{ROW_WORD, 8'h20, 1'b1, 2'd1, res_word(8'h00, 0, 0, 1, 0), NO_RES}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_MODE) begin
				settle();
				write_reg(pfs_pkg::REG_CIPHER_MODE,
					pfs_pkg::CFG_DATA_W'(dir_rows[i].data[0]));
				wr_en <= 1'b0;
			end else begin
				offer_word(dir_rows[i].data, dir_rows[i].fin);
				if (dir_rows[i].ntyped == 2'd0)
					take_prediction();
				else begin
					enqueue_word(dir_rows[i].r0);
					if (dir_rows[i].ntyped == 2'd2)
						enqueue_word(dir_rows[i].r1);
				end
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			calm = (p == PHASES - 1);
			plan_mode = (p inside {1, 3, 5, 6});
			unique case (p)
				2: foreach (plan_rows[i]) plan_rows[i] = '0;
				3: foreach (plan_rows[i]) plan_rows[i] = '1;
				4: foreach (plan_rows[i]) plan_rows[i] = pfs_pkg::ROW_W'($urandom);
				5: foreach (plan_rows[i]) plan_rows[i] = pfs_pkg::SQUARE_RESET[i];
				default: begin
					foreach (codes[i])
						codes[i] = pfs_pkg::CODE_W'(i);
					for (int i = 25; i > 0; i--) begin
						k = $urandom_range(0, i);
						t = codes[i];
						codes[i] = codes[k];
						codes[k] = t;
					end
					foreach (plan_rows[i])
						for (int j = 0; j < pfs_pkg::SQUARE_SIDE; j++)
							plan_rows[i][pfs_pkg::CODE_W * j +: pfs_pkg::CODE_W] =
								codes[i * pfs_pkg::SQUARE_SIDE + j];
				end
			endcase
			write_reg(pfs_pkg::REG_CIPHER_MODE, pfs_pkg::CFG_DATA_W'(plan_mode));
			foreach (plan_rows[i])
				write_reg(pfs_pkg::cfg_reg_t'(int'(pfs_pkg::REG_SQUARE_ROW0) + i),
					plan_rows[i]);
			wr_en <= 1'b0;

			quota = 0;
			while (quota < PHASE_WORDS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				prev = "e";
				for (int i = 0; i < len; i++) begin
					roll = $urandom_range(0, 99);
					if (roll < 8)
						b = 8'($urandom_range(0, 255));
					else if (!key_mode && roll < 20 && i > 0)
						b = prev ^ ($urandom_range(0, 1) ? pfs_pkg::CASE_BIT : 8'h00);
					else if (!key_mode) begin
						b = pfs_pkg::CHAR_A + 8'($urandom_range(0, 25));
						if ($urandom_range(0, 3) == 0)
							b = b & ~pfs_pkg::CASE_BIT;
					end else begin
						r = $urandom_range(0, pfs_pkg::SQUARE_SIDE - 1);
						c = $urandom_range(0, pfs_pkg::SQUARE_SIDE - 1);
						b = pfs_pkg::CHAR_A +
							8'(key_rows[r][pfs_pkg::CODE_W * c +: pfs_pkg::CODE_W]);
					end
					offer_word(b, i == len - 1);
					take_prediction();
					if (key_mode || ((b | pfs_pkg::CASE_BIT) >= pfs_pkg::CHAR_A &&
							(b | pfs_pkg::CASE_BIT) <= pfs_pkg::CHAR_Z))
						quota++;
					prev = b;
				end
			end
		end

		settle();
		if (mismatches == 0 && pending_letters.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : result_sink
		int hold;
		bit squeezed;
		squeezed = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			// hold off long enough to fill the block and stall its input
			if (!squeezed && words_sent >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				hold = SQUEEZE_CYCLES;
				res_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				hold = $urandom_range(1, 14);
				res_ch.ready <= 1'b0;
			end else begin
				hold = calm ? 1 : $urandom_range(1, 20);
				res_ch.ready <= 1'b1;
			end
			repeat (hold) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		pfs_pkg::result_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_word(res_ch.out_letter, res_ch.letter_valid, res_ch.pair_second,
				res_ch.message_end, res_ch.bad_input);
			if (pending_letters.size() == 0)
				report_fault("unexpected word", NO_RES, got);
			else begin
				want = pending_letters.pop_front();
				if (got !== want)
					report_fault("wrong word", want, got);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready) || wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/pfs_pkg.sv
rtl/core/pfs_stream_if.sv
rtl/core/pfs_cfg_regs.sv
rtl/core/pfs_pair_xform.sv
rtl/core/pfs_prep_stage.sv
rtl/core/pfs_result_queue.sv
rtl/core/playfair_cipher_stream.sv
rtl/core/pfs_checker.sv
tb/sv/playfair_cipher_stream_tb.sv
